FILE: sv/ipss_pkg.sv
// shared constants, types and an atan table function for the photon scatter step
`timescale 1ns / 1ps
`default_nettype none
package ipss_pkg;

    localparam int CORDIC_STEPS = 30;
    localparam int LOG_STEPS    = 30;
    localparam int SQRT_STEPS   = 32;

    localparam logic [31:0] CORDIC_K = 32'h26DD3B6A;
    localparam logic [31:0] PI_Q28   = 32'h3243F6A8;
    localparam logic [31:0] LN2_Q28  = 32'h0B172180;
    localparam logic signed [18:0] UNIT_DIR = 19'sd65536;

    localparam logic [31:0] MFP_RESET = 32'h0001_0000;

    typedef enum logic [0:0] {
        REG_MEAN_FREE_PATH = 1'b0
    } reg_index_t;

    function automatic logic signed [32:0] atan_q30(input logic [4:0] i);
        logic signed [32:0] r;
        begin
            case (i)
                5'd0:  r = 33'sh03243F6A8;
                5'd1:  r = 33'sh01DAC6705;
                5'd2:  r = 33'sh00FADBAFC;
                5'd3:  r = 33'sh007F56EA6;
                5'd4:  r = 33'sh003FEAB76;
                5'd5:  r = 33'sh001FFD55B;
                5'd6:  r = 33'sh000FFFAAA;
                5'd7:  r = 33'sh0007FFF55;
                5'd8:  r = 33'sh0003FFFEA;
                5'd9:  r = 33'sh0001FFFFD;
                5'd10: r = 33'sh0000FFFFF;
                5'd11: r = 33'sh00007FFFF;
                5'd12: r = 33'sh00003FFFF;
                5'd13: r = 33'sh00001FFFF;
                5'd14: r = 33'sh00000FFFF;
                5'd15: r = 33'sh000007FFF;
                5'd16: r = 33'sh000003FFF;
                5'd17: r = 33'sh000001FFF;
                5'd18: r = 33'sh000000FFF;
                5'd19: r = 33'sh0000007FF;
                5'd20: r = 33'sh0000003FF;
                5'd21: r = 33'sh0000001FF;
                5'd22: r = 33'sh0000000FF;
                5'd23: r = 33'sh00000007F;
                5'd24: r = 33'sh00000003F;
                5'd25: r = 33'sh00000001F;
                5'd26: r = 33'sh00000000F;
                5'd27: r = 33'sh000000007;
                5'd28: r = 33'sh000000003;
                5'd29: r = 33'sh000000001;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

    // payload handed from cell to cell
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic        [31:0] mfp;
        logic        [31:0] fc;
        logic         [1:0] quad;
        logic signed [33:0] cx;
        logic signed [33:0] cy;
        logic signed [32:0] cz;
        logic        [63:0] sq_n;
        logic        [63:0] sq_res;
        logic         [5:0] lz_exp;
        logic        [32:0] lg_m;
        logic        [29:0] lg_frac;
    } cell_data_t;

endpackage
`default_nettype wire

FILE: sv/ipss_cell.sv
// one cell: a square root digit, plus a cordic rotation and a log squaring step while IDX is below their step counts
`timescale 1ns / 1ps
`default_nettype none
module ipss_cell
    import ipss_pkg::*;
#(
    parameter int IDX = 0
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       en,
    input  wire logic       vld_in,
    input  cell_data_t      d_in,
    output logic            vld_out,
    output cell_data_t      d_out
);

    localparam int SQ_SH = 62 - 2 * IDX;
    localparam logic [4:0] CI = 5'(IDX);

    logic       vld_reg;
    cell_data_t d_reg;
    cell_data_t d_next;

    logic signed [33:0] xs, ys;
    logic        [63:0] sq_bit;
    logic        [63:0] sq_trial;
    logic        [65:0] m_sq;
    logic        [33:0] m_new;

    always_comb begin
        d_next = d_in;
        // cordic step
        xs = d_in.cx >>> IDX;
        ys = d_in.cy >>> IDX;
        if (IDX < CORDIC_STEPS) begin
            if (!d_in.cz[32]) begin
                d_next.cx = d_in.cx - ys;
                d_next.cy = d_in.cy + xs;
                d_next.cz = d_in.cz - atan_q30(CI);
            end else begin
                d_next.cx = d_in.cx + ys;
                d_next.cy = d_in.cy - xs;
                d_next.cz = d_in.cz + atan_q30(CI);
            end
        end
        // square root digit
        sq_bit   = 64'd1 << SQ_SH;
        sq_trial = d_in.sq_res + sq_bit;
        if (d_in.sq_n >= sq_trial) begin
            d_next.sq_n   = d_in.sq_n - sq_trial;
            d_next.sq_res = (d_in.sq_res >> 1) + sq_bit;
        end else begin
            d_next.sq_res = d_in.sq_res >> 1;
        end
        // log squaring step
        m_sq  = 66'({d_in.lg_m} * {d_in.lg_m});
        m_new = 34'(m_sq >> 31);
        if (IDX < LOG_STEPS) begin
            if (m_new[32] || m_new[33]) begin
                d_next.lg_m    = 33'(m_new >> 1);
                d_next.lg_frac = {d_in.lg_frac[28:0], 1'b1};
            end else begin
                d_next.lg_m    = m_new[32:0];
                d_next.lg_frac = {d_in.lg_frac[28:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (en) begin
            vld_reg <= vld_in;
        end
        if (en) begin
            d_reg <= d_next;
        end
    end

    assign vld_out = vld_reg;
    assign d_out   = d_reg;

endmodule
`default_nettype wire

FILE: sv/isotropic_photon_scatter_step.sv
// top level of the photon scatter step: front end, cell chain, back end
//  channel | direction | fields
//  s_      | in        | pos_x pos_y pos_z rand_azimuth rand_cosine rand_length
//  m_      | out       | new_x new_y new_z dir_u dir_v dir_w step_length overflow
//  apb     | in/out    | mean_free_path at byte address 0
// one item per cycle while not stalled; front stages 1-2, cell chain, back stages 1-4, output register
// the whole pipe advances when the output register is empty or being taken
// a stall on m_ready holds every stage; s_ready follows the same enable
// reset clears valid bits and loads mean_free_path with 1.0
`timescale 1ns / 1ps
`default_nettype none
module isotropic_photon_scatter_step
    import ipss_pkg::*;
#(
    parameter int RAND_BITS = 24
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic            [1:0] paddr,
    input  wire logic           [31:0] pwdata,
    output logic                [31:0] prdata,
    output logic                       pready,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic signed    [31:0] s_pos_x,
    input  wire logic signed    [31:0] s_pos_y,
    input  wire logic signed    [31:0] s_pos_z,
    input  wire logic  [RAND_BITS-1:0] s_rand_azimuth,
    input  wire logic  [RAND_BITS-1:0] s_rand_cosine,
    input  wire logic  [RAND_BITS-1:0] s_rand_length,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic signed         [31:0] m_new_x,
    output logic signed         [31:0] m_new_y,
    output logic signed         [31:0] m_new_z,
    output logic signed         [17:0] m_dir_u,
    output logic signed         [17:0] m_dir_v,
    output logic signed         [17:0] m_dir_w,
    output logic                [31:0] m_step_length,
    output logic                       m_overflow
);

    localparam int SH    = 32 - RAND_BITS;
    localparam int NCELL = SQRT_STEPS;

    logic en;
    logic [31:0] mfp_reg;

    assign pready = 1'b1;
    assign prdata = mfp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mfp_reg <= MFP_RESET;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'(REG_MEAN_FREE_PATH)) begin
            mfp_reg <= pwdata;
        end
    end

    // ---------------- front stage 1: turn split, w, leading one
    logic        f1_vld_reg;
    logic signed [31:0] f1_px_reg, f1_py_reg, f1_pz_reg;
    logic [31:0] f1_mfp_reg, f1_fc_reg;
    logic [1:0]  f1_q_reg;
    logic        f1_neg_reg;
    logic [29:0] f1_m_reg;
    logic [63:0] f1_sqn_reg;
    logic [5:0]  f1_n_reg;
    logic [32:0] f1_lm_reg;

    logic [31:0] fa, fc, a_t;
    logic [32:0] fl;
    logic signed [32:0] dd, w31;
    logic [31:0] wm;
    logic [5:0]  n_c;
    logic [32:0] lm_c;

    always_comb begin
        fa  = 32'(s_rand_azimuth) << SH;
        fc  = 32'(s_rand_cosine) << SH;
        fl  = (33'(s_rand_length) + 33'd1) << SH;
        a_t = fa + 32'h2000_0000;
        dd  = $signed({3'b000, a_t[29:0]}) - 33'sh020000000;
        w31 = $signed({1'b0, fc}) - 33'sh080000000;
        wm  = w31[32] ? 32'(-w31) : w31[31:0];
        n_c = '0;
        for (int b = 0; b < 33; b++) begin
            if (fl[b]) n_c = 6'(b);
        end
        if (n_c > 6'd31) lm_c = fl >> 1;
        else             lm_c = 33'(fl << (6'd31 - n_c));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
        end else if (en) begin
            f1_vld_reg <= s_valid;
        end
        if (en) begin
            f1_px_reg  <= s_pos_x;
            f1_py_reg  <= s_pos_y;
            f1_pz_reg  <= s_pos_z;
            f1_mfp_reg <= mfp_reg;
            f1_fc_reg  <= fc;
            f1_q_reg   <= a_t[31:30];
            f1_neg_reg <= dd[32];
            f1_m_reg   <= dd[32] ? 30'(-dd) : dd[29:0];
            f1_sqn_reg <= 64'h4000_0000_0000_0000 - 64'(wm) * 64'(wm);
            f1_n_reg   <= n_c;
            f1_lm_reg  <= lm_c;
        end
    end

    // ---------------- front stage 2: radians
    logic        f2_vld_reg;
    cell_data_t  f2_reg;
    logic [61:0] rad_p;
    logic signed [32:0] z0;

    always_comb begin
        rad_p = 62'(({32'd0, f1_m_reg} * 62'(PI_Q28) + (62'd1 << 28)) >> 29);
        z0    = f1_neg_reg ? -$signed(33'(rad_p)) : $signed(33'(rad_p));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f2_vld_reg <= 1'b0;
        end else if (en) begin
            f2_vld_reg <= f1_vld_reg;
        end
        if (en) begin
            f2_reg.pos_x   <= f1_px_reg;
            f2_reg.pos_y   <= f1_py_reg;
            f2_reg.pos_z   <= f1_pz_reg;
            f2_reg.mfp     <= f1_mfp_reg;
            f2_reg.fc      <= f1_fc_reg;
            f2_reg.quad    <= f1_q_reg;
            f2_reg.cx      <= $signed({2'b00, CORDIC_K});
            f2_reg.cy      <= '0;
            f2_reg.cz      <= z0;
            f2_reg.sq_n    <= f1_sqn_reg;
            f2_reg.sq_res  <= '0;
            f2_reg.lz_exp  <= f1_n_reg;
            f2_reg.lg_m    <= f1_lm_reg;
            f2_reg.lg_frac <= '0;
        end
    end

    // ---------------- cell chain
    logic       c_vld [NCELL+1];
    cell_data_t c_dat [NCELL+1];
    assign c_vld[0] = f2_vld_reg;
    assign c_dat[0] = f2_reg;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        ipss_cell #(.IDX(g)) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (en),
            .vld_in  (c_vld[g]),
            .d_in    (c_dat[g]),
            .vld_out (c_vld[g+1]),
            .d_out   (c_dat[g+1])
        );
    end

    cell_data_t ce;
    assign ce = c_dat[NCELL];

    // ---------------- back stage 1: quadrant, products, neglog
    logic b1_vld_reg;
    logic signed [31:0] b1_px_reg, b1_py_reg, b1_pz_reg;
    logic [31:0] b1_mfp_reg;
    logic signed [18:0] b1_w_reg;
    logic signed [67:0] b1_cu_reg, b1_sv_reg;
    logic [36:0] b1_nl_reg;
    logic signed [33:0] cc, ss;
    logic [32:0] wr;

    always_comb begin
        case (ce.quad)
            2'd0:    begin cc = ce.cx;  ss = ce.cy;  end
            2'd1:    begin cc = -ce.cy; ss = ce.cx;  end
            2'd2:    begin cc = -ce.cx; ss = -ce.cy; end
            default: begin cc = ce.cy;  ss = -ce.cx; end
        endcase
        wr = ({1'b0, ce.fc} + 33'h4000) >> 15;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_vld_reg <= 1'b0;
        end else if (en) begin
            b1_vld_reg <= c_vld[NCELL];
        end
        if (en) begin
            b1_px_reg  <= ce.pos_x;
            b1_py_reg  <= ce.pos_y;
            b1_pz_reg  <= ce.pos_z;
            b1_mfp_reg <= ce.mfp;
            b1_w_reg   <= $signed({1'b0, wr[17:0]}) - UNIT_DIR;
            b1_cu_reg  <= 68'(cc) * $signed({36'd0, ce.sq_res[31:0]});
            b1_sv_reg  <= 68'(ss) * $signed({36'd0, ce.sq_res[31:0]});
            b1_nl_reg  <= (37'(6'd32 - ce.lz_exp) << 30) - 37'(ce.lg_frac);
        end
    end

    // ---------------- back stage 2: direction clamp, ln2 scaling
    logic b2_vld_reg;
    logic signed [31:0] b2_px_reg, b2_py_reg, b2_pz_reg;
    logic [31:0] b2_mfp_reg;
    logic signed [18:0] b2_u_reg, b2_v_reg, b2_w_reg;
    logic [34:0] b2_nl24_reg;
    logic signed [67:0] ru, rv;
    logic signed [22:0] tu, tv;
    logic signed [18:0] cu, cv;

    always_comb begin
        ru = (b1_cu_reg + (68'sd1 <<< 44)) >>> 45;
        rv = (b1_sv_reg + (68'sd1 <<< 44)) >>> 45;
        tu = 23'(ru);
        tv = 23'(rv);
        cu = (tu > 23'sd65536) ? UNIT_DIR : (tu < -23'sd65536) ? -UNIT_DIR : 19'(tu);
        cv = (tv > 23'sd65536) ? UNIT_DIR : (tv < -23'sd65536) ? -UNIT_DIR : 19'(tv);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b2_vld_reg <= 1'b0;
        end else if (en) begin
            b2_vld_reg <= b1_vld_reg;
        end
        if (en) begin
            b2_px_reg   <= b1_px_reg;
            b2_py_reg   <= b1_py_reg;
            b2_pz_reg   <= b1_pz_reg;
            b2_mfp_reg  <= b1_mfp_reg;
            b2_u_reg    <= cu;
            b2_v_reg    <= cv;
            b2_w_reg    <= b1_w_reg;
            b2_nl24_reg <= 35'((69'(b1_nl_reg) * 69'(LN2_Q28) + (69'd1 << 33)) >> 34);
        end
    end

    // ---------------- back stage 3: length
    logic b3_vld_reg;
    logic signed [31:0] b3_px_reg, b3_py_reg, b3_pz_reg;
    logic signed [18:0] b3_u_reg, b3_v_reg, b3_w_reg;
    logic [31:0] b3_len_reg;
    logic        b3_lo_reg;
    logic [66:0] lp;

    always_comb begin
        lp = (67'(b2_nl24_reg) * 67'(b2_mfp_reg) + (67'd1 << 23)) >> 24;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b3_vld_reg <= 1'b0;
        end else if (en) begin
            b3_vld_reg <= b2_vld_reg;
        end
        if (en) begin
            b3_px_reg  <= b2_px_reg;
            b3_py_reg  <= b2_py_reg;
            b3_pz_reg  <= b2_pz_reg;
            b3_u_reg   <= b2_u_reg;
            b3_v_reg   <= b2_v_reg;
            b3_w_reg   <= b2_w_reg;
            b3_lo_reg  <= |lp[66:32];
            b3_len_reg <= (|lp[66:32]) ? 32'hFFFF_FFFF : lp[31:0];
        end
    end

    // ---------------- back stage 4: deltas
    logic b4_vld_reg;
    logic signed [31:0] b4_px_reg, b4_py_reg, b4_pz_reg;
    logic signed [18:0] b4_u_reg, b4_v_reg, b4_w_reg;
    logic [31:0] b4_len_reg;
    logic        b4_lo_reg;
    logic signed [51:0] b4_du_reg, b4_dv_reg, b4_dw_reg;
    logic signed [51:0] lsg;

    assign lsg = $signed({20'd0, b3_len_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b4_vld_reg <= 1'b0;
        end else if (en) begin
            b4_vld_reg <= b3_vld_reg;
        end
        if (en) begin
            b4_px_reg  <= b3_px_reg;
            b4_py_reg  <= b3_py_reg;
            b4_pz_reg  <= b3_pz_reg;
            b4_u_reg   <= b3_u_reg;
            b4_v_reg   <= b3_v_reg;
            b4_w_reg   <= b3_w_reg;
            b4_len_reg <= b3_len_reg;
            b4_lo_reg  <= b3_lo_reg;
            b4_du_reg  <= (lsg * 52'(b3_u_reg) + 52'sd32768) >>> 16;
            b4_dv_reg  <= (lsg * 52'(b3_v_reg) + 52'sd32768) >>> 16;
            b4_dw_reg  <= (lsg * 52'(b3_w_reg) + 52'sd32768) >>> 16;
        end
    end

    // ---------------- output register: add and saturate
    logic signed [52:0] sx, sy, sz;
    logic ox, oy, oz;
    logic signed [31:0] nx, ny, nz;
    localparam logic signed [52:0] PMAX = 53'sd2147483647;
    localparam logic signed [52:0] PMIN = -53'sd2147483648;

    always_comb begin
        sx = 53'(b4_px_reg) + 53'(b4_du_reg);
        sy = 53'(b4_py_reg) + 53'(b4_dv_reg);
        sz = 53'(b4_pz_reg) + 53'(b4_dw_reg);
        ox = (sx > PMAX) || (sx < PMIN);
        oy = (sy > PMAX) || (sy < PMIN);
        oz = (sz > PMAX) || (sz < PMIN);
        nx = (sx > PMAX) ? 32'sh7FFFFFFF : (sx < PMIN) ? 32'sh80000000 : sx[31:0];
        ny = (sy > PMAX) ? 32'sh7FFFFFFF : (sy < PMIN) ? 32'sh80000000 : sy[31:0];
        nz = (sz > PMAX) ? 32'sh7FFFFFFF : (sz < PMIN) ? 32'sh80000000 : sz[31:0];
    end

    logic o_vld_reg;
    assign en      = !o_vld_reg || m_ready;
    assign s_ready = en;
    assign m_valid = o_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_vld_reg <= 1'b0;
        end else if (en) begin
            o_vld_reg <= b4_vld_reg;
        end
        if (en) begin
            m_new_x       <= nx;
            m_new_y       <= ny;
            m_new_z       <= nz;
            m_dir_u       <= b4_u_reg[17:0];
            m_dir_v       <= b4_v_reg[17:0];
            m_dir_w       <= b4_w_reg[17:0];
            m_step_length <= b4_len_reg;
            m_overflow    <= b4_lo_reg || ox || oy || oz;
        end
    end

endmodule
`default_nettype wire

FILE: sv/ipss_checker.sv
// port level checks for the photon scatter step, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module ipss_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [17:0] m_dir_w,
    input wire logic [31:0] m_step_length,
    input wire logic        m_overflow,
    input wire logic        pready
);

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_step_length) && $stable(m_overflow)
            && $stable(m_dir_w))
        else $error("result dropped under stall");

    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while pipe stalled");

    a_dir_w_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> $signed(m_dir_w) >= -18'sd65536 && $signed(m_dir_w) <= 18'sd65536)
        else $error("dir_w outside unit range");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn) pready)
        else $error("pready low");

endmodule

bind isotropic_photon_scatter_step ipss_checker u_ipss_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_dir_w       (m_dir_w),
    .m_step_length (m_step_length),
    .m_overflow    (m_overflow),
    .pready        (pready)
);
`default_nettype wire
